FILE: hw/rtl/wlsf_pkg.sv
// Shared widths, status codes and sequencer codes for the weighted line fit.
// Used by wlsf_mul, wlsf_div and weighted_least_squares_line_fit. No dependencies.
`default_nettype none

package wlsf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SW_W     = 26;
    localparam int SX_W     = 42;
    localparam int SXX_W    = 58;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int OPD_W    = 58;
    localparam int HALF_W   = 29;
    localparam int ACC_W    = 100;
    localparam int FRAC_W   = 16;
    localparam int QUO_W    = ACC_W + FRAC_W + 1;
    localparam int OUT_W    = 48;
    localparam int DIV_CNT_W = $clog2(QUO_W + 1);

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SINGULAR = 2'd1;
    localparam logic [1:0] STATUS_IGNORED  = 2'd2;

    localparam logic [1:0] DET_MAIN      = 2'd0;
    localparam logic [1:0] DET_INTERCEPT = 2'd1;
    localparam logic [1:0] DET_SLOPE     = 2'd2;

    localparam logic [1:0] SHIFT_NONE = 2'd0;
    localparam logic [1:0] SHIFT_HALF = 2'd1;
    localparam logic [1:0] SHIFT_FULL = 2'd2;

    localparam logic [OUT_W-1:0] SAT_POS = 48'h7FFF_FFFF_FFFF;
    localparam logic [OUT_W-1:0] SAT_NEG = 48'h8000_0000_0000;

endpackage

`default_nettype wire

FILE: hw/rtl/wlsf_mul.sv
// Shared unsigned 32x32 multiplier with a registered product.
// Depends on wlsf_pkg.
`default_nettype none

module wlsf_mul
(
    input  wire logic                       clk,
    input  wire logic [wlsf_pkg::MUL_W-1:0] a,
    input  wire logic [wlsf_pkg::MUL_W-1:0] b,
    output logic      [wlsf_pkg::PROD_W-1:0] product
);

    logic [wlsf_pkg::PROD_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= a * b;
    end

    assign product = product_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/wlsf_div.sv
// Restoring divider, one quotient bit per cycle; numerator is scaled by 2^17.
// Depends on wlsf_pkg.
`default_nettype none

module wlsf_div
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [wlsf_pkg::ACC_W-1:0] num_mag,
    input  wire logic [wlsf_pkg::ACC_W-1:0] den_mag,
    output logic                            done,
    output logic      [wlsf_pkg::QUO_W-1:0] quotient
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [wlsf_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [wlsf_pkg::QUO_W-1:0]         n_reg;
    logic [wlsf_pkg::ACC_W-1:0]         r_reg;
    logic [wlsf_pkg::ACC_W-1:0]         d_reg;

    logic [wlsf_pkg::ACC_W:0]           r_shift;
    logic [wlsf_pkg::ACC_W+1:0]         diff;
    logic                               ge;
    logic [wlsf_pkg::ACC_W-1:0]         r_next;

    assign r_shift = {r_reg, n_reg[wlsf_pkg::QUO_W-1]};
    assign diff    = {1'b0, r_shift} - {2'b00, d_reg};
    assign ge      = ~diff[wlsf_pkg::ACC_W+1];
    assign r_next  = ge ? diff[wlsf_pkg::ACC_W-1:0] : r_shift[wlsf_pkg::ACC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == wlsf_pkg::DIV_CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= wlsf_pkg::DIV_CNT_W'(wlsf_pkg::QUO_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - wlsf_pkg::DIV_CNT_W'(1);
                if (cnt_reg == wlsf_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // quotient bits shift in behind the numerator bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= {num_mag, {(wlsf_pkg::FRAC_W + 1){1'b0}}};
            r_reg <= '0;
            d_reg <= den_mag;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[wlsf_pkg::QUO_W-2:0], ge};
            r_reg <= r_next;
        end
    end

    assign done     = done_reg;
    assign quotient = n_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/weighted_least_squares_line_fit.sv
// Weighted least-squares line fit: sequencer, running sums and Cramer solve.
// Depends on wlsf_pkg, wlsf_mul and wlsf_div.
//
//   channel   handshake          payload
//   command   start / busy       x_value, y_value, weight, last
//   result    done (one cycle)   intercept, slope, status
//
// A held sample passes through S_WX, S_WY, S_WXX, S_WXY and S_ACC (four
// products through the shared 32x32 multiplier, then the sums); a sample beyond
// capacity is dropped and sets the overflow flag. After any last sample the solve
// runs three determinants in S_PROD (four partial products per 58-bit product),
// each followed by S_EVAL, and two bit-serial divisions of 117 quotient bits.
// A singular set ends after the first determinant. Reset is asynchronous and
// clears the sums, count and overflow flag. The receiver cannot stall: done
// marks each result transfer for exactly one cycle.
`default_nettype none

module weighted_least_squares_line_fit
#(
    parameter int MAX_POINTS = 1024
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic signed [wlsf_pkg::SAMPLE_W-1:0]  x_value,
    input  wire logic signed [wlsf_pkg::SAMPLE_W-1:0]  y_value,
    input  wire logic        [wlsf_pkg::SAMPLE_W-1:0]  weight,
    input  wire logic                                  last,
    output logic                                       done,
    output logic signed      [wlsf_pkg::OUT_W-1:0]     intercept,
    output logic signed      [wlsf_pkg::OUT_W-1:0]     slope,
    output logic             [1:0]                     status
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WX   = 4'd1;
    localparam logic [3:0] S_WY   = 4'd2;
    localparam logic [3:0] S_WXX  = 4'd3;
    localparam logic [3:0] S_WXY  = 4'd4;
    localparam logic [3:0] S_ACC  = 4'd5;
    localparam logic [3:0] S_PROD = 4'd6;
    localparam logic [3:0] S_EVAL = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;

    localparam logic [3:0] STEP_LAST = 4'd8;

    logic [3:0]                          state_reg;
    logic [3:0]                          state_next;

    logic [wlsf_pkg::SAMPLE_W-1:0]       x_reg;
    logic [wlsf_pkg::SAMPLE_W-1:0]       y_reg;
    logic [wlsf_pkg::SAMPLE_W-1:0]       w_reg;
    logic                                last_reg;
    logic [wlsf_pkg::MUL_W-1:0]          wx_mag_reg;

    logic [wlsf_pkg::SW_W-1:0]           sum_w_reg;
    logic [wlsf_pkg::SX_W-1:0]           sum_wx_reg;
    logic [wlsf_pkg::SX_W-1:0]           sum_wy_reg;
    logic [wlsf_pkg::SXX_W-1:0]          sum_wxx_reg;
    logic [wlsf_pkg::SXX_W-1:0]          sum_wxy_reg;
    logic [CNT_W-1:0]                    count_reg;
    logic                                overflow_reg;

    logic [1:0]                          det_sel_reg;
    logic [3:0]                          step_reg;
    logic                                pp_neg_reg;
    logic [1:0]                          pp_shift_reg;
    logic [wlsf_pkg::ACC_W-1:0]          acc_reg;
    logic [wlsf_pkg::ACC_W-1:0]          den_mag_reg;
    logic                                den_neg_reg;
    logic                                quo_neg_reg;
    logic [wlsf_pkg::OUT_W-1:0]          intercept_reg;
    logic [wlsf_pkg::OUT_W-1:0]          slope_reg;
    logic [1:0]                          status_reg;
    logic                                done_reg;

    logic [wlsf_pkg::SAMPLE_W-1:0]       ax;
    logic [wlsf_pkg::SAMPLE_W-1:0]       ay;
    logic                                sx;
    logic                                sy;
    logic                                room;

    logic [wlsf_pkg::MUL_W-1:0]          mul_a;
    logic [wlsf_pkg::MUL_W-1:0]          mul_b;
    logic [wlsf_pkg::PROD_W-1:0]         product;
    logic [wlsf_pkg::SX_W-1:0]           p_sx;
    logic [wlsf_pkg::SXX_W-1:0]          p_sxx;

    logic                                term;
    logic [wlsf_pkg::OPD_W-1:0]          opd_a;
    logic [wlsf_pkg::OPD_W-1:0]          opd_b;
    logic [wlsf_pkg::OPD_W-1:0]          mag_a;
    logic [wlsf_pkg::OPD_W-1:0]          mag_b;
    logic [wlsf_pkg::HALF_W-1:0]         half_a;
    logic [wlsf_pkg::HALF_W-1:0]         half_b;
    logic [1:0]                          issue_shift;
    logic                                issue_neg;

    logic [wlsf_pkg::ACC_W-1:0]          pp_ext;
    logic [wlsf_pkg::ACC_W-1:0]          pp_shifted;
    logic [wlsf_pkg::ACC_W-1:0]          pp_term;
    logic                                acc_neg;
    logic [wlsf_pkg::ACC_W-1:0]          acc_mag;
    logic                                acc_zero;

    logic                                div_start;
    logic                                div_done;
    logic [wlsf_pkg::QUO_W-1:0]          div_quotient;
    logic [wlsf_pkg::QUO_W:0]            quo_plus;
    logic [wlsf_pkg::QUO_W-1:0]          quo_round;
    logic [wlsf_pkg::OUT_W-1:0]          fixed_mag;
    logic [wlsf_pkg::OUT_W-1:0]          fixed_val;

    logic                                solve_go;
    logic                                next_det;
    logic                                intercept_fire;
    logic                                result_fire;
    logic                                singular_fire;

    assign sx   = x_reg[wlsf_pkg::SAMPLE_W-1];
    assign sy   = y_reg[wlsf_pkg::SAMPLE_W-1];
    assign ax   = sx ? (-x_reg) : x_reg;
    assign ay   = sy ? (-y_reg) : y_reg;
    assign room = count_reg < CNT_W'(MAX_POINTS);

    assign p_sx  = product[wlsf_pkg::SX_W-1:0];
    assign p_sxx = product[wlsf_pkg::SXX_W-1:0];

    // operands of the current determinant term, extended to 58 bits (sums sign-extended, sum_w zero-extended)
    assign term = step_reg[2];

    always_comb
    begin
        unique case (det_sel_reg)
            wlsf_pkg::DET_MAIN:
            begin
                opd_a = term ? {{(wlsf_pkg::OPD_W - wlsf_pkg::SX_W){sum_wx_reg[wlsf_pkg::SX_W-1]}},
                                sum_wx_reg}
                             : wlsf_pkg::OPD_W'(sum_w_reg);
                opd_b = term ? {{(wlsf_pkg::OPD_W - wlsf_pkg::SX_W){sum_wx_reg[wlsf_pkg::SX_W-1]}},
                                sum_wx_reg}
                             : sum_wxx_reg;
            end
            wlsf_pkg::DET_INTERCEPT:
            begin
                opd_a = term ? sum_wxy_reg
                             : {{(wlsf_pkg::OPD_W - wlsf_pkg::SX_W){sum_wy_reg[wlsf_pkg::SX_W-1]}},
                                sum_wy_reg};
                opd_b = term ? {{(wlsf_pkg::OPD_W - wlsf_pkg::SX_W){sum_wx_reg[wlsf_pkg::SX_W-1]}},
                                sum_wx_reg}
                             : sum_wxx_reg;
            end
            default:
            begin
                opd_a = term ? {{(wlsf_pkg::OPD_W - wlsf_pkg::SX_W){sum_wx_reg[wlsf_pkg::SX_W-1]}},
                                sum_wx_reg}
                             : wlsf_pkg::OPD_W'(sum_w_reg);
                opd_b = term ? {{(wlsf_pkg::OPD_W - wlsf_pkg::SX_W){sum_wy_reg[wlsf_pkg::SX_W-1]}},
                                sum_wy_reg}
                             : sum_wxy_reg;
            end
        endcase
    end

    assign mag_a = opd_a[wlsf_pkg::OPD_W-1] ? (-opd_a) : opd_a;
    assign mag_b = opd_b[wlsf_pkg::OPD_W-1] ? (-opd_b) : opd_b;
    assign issue_neg = opd_a[wlsf_pkg::OPD_W-1] ^ opd_b[wlsf_pkg::OPD_W-1] ^ term;

    always_comb
    begin
        case (step_reg[1:0])
            2'd0:
            begin
                half_a      = mag_a[wlsf_pkg::HALF_W-1:0];
                half_b      = mag_b[wlsf_pkg::HALF_W-1:0];
                issue_shift = wlsf_pkg::SHIFT_NONE;
            end
            2'd1:
            begin
                half_a      = mag_a[wlsf_pkg::HALF_W-1:0];
                half_b      = mag_b[wlsf_pkg::OPD_W-1:wlsf_pkg::HALF_W];
                issue_shift = wlsf_pkg::SHIFT_HALF;
            end
            2'd2:
            begin
                half_a      = mag_a[wlsf_pkg::OPD_W-1:wlsf_pkg::HALF_W];
                half_b      = mag_b[wlsf_pkg::HALF_W-1:0];
                issue_shift = wlsf_pkg::SHIFT_HALF;
            end
            default:
            begin
                half_a      = mag_a[wlsf_pkg::OPD_W-1:wlsf_pkg::HALF_W];
                half_b      = mag_b[wlsf_pkg::OPD_W-1:wlsf_pkg::HALF_W];
                issue_shift = wlsf_pkg::SHIFT_FULL;
            end
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            S_WX:
            begin
                mul_a = wlsf_pkg::MUL_W'(w_reg);
                mul_b = wlsf_pkg::MUL_W'(ax);
            end
            S_WY:
            begin
                mul_a = wlsf_pkg::MUL_W'(w_reg);
                mul_b = wlsf_pkg::MUL_W'(ay);
            end
            S_WXX:
            begin
                mul_a = wx_mag_reg;
                mul_b = wlsf_pkg::MUL_W'(ax);
            end
            S_WXY:
            begin
                mul_a = wx_mag_reg;
                mul_b = wlsf_pkg::MUL_W'(ay);
            end
            S_PROD:
            begin
                mul_a = wlsf_pkg::MUL_W'(half_a);
                mul_b = wlsf_pkg::MUL_W'(half_b);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    wlsf_mul u_mul
    (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    assign pp_ext = wlsf_pkg::ACC_W'(product);

    always_comb
    begin
        case (pp_shift_reg)
            wlsf_pkg::SHIFT_NONE: pp_shifted = pp_ext;
            wlsf_pkg::SHIFT_HALF: pp_shifted = pp_ext << wlsf_pkg::HALF_W;
            default:              pp_shifted = pp_ext << (2 * wlsf_pkg::HALF_W);
        endcase
    end

    assign pp_term  = pp_neg_reg ? (-pp_shifted) : pp_shifted;
    assign acc_neg  = acc_reg[wlsf_pkg::ACC_W-1];
    assign acc_mag  = acc_neg ? (-acc_reg) : acc_reg;
    assign acc_zero = (acc_reg == '0);

    assign div_start = (state_reg == S_EVAL) && (det_sel_reg != wlsf_pkg::DET_MAIN);

    wlsf_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num_mag  (acc_mag),
        .den_mag  (den_mag_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // round half away from zero, then saturate to Q31.16
    assign quo_plus  = {1'b0, div_quotient} + (wlsf_pkg::QUO_W + 1)'(1);
    assign quo_round = quo_plus[wlsf_pkg::QUO_W:1];

    always_comb
    begin
        if (quo_neg_reg)
        begin
            fixed_mag = (quo_round > wlsf_pkg::QUO_W'(wlsf_pkg::SAT_NEG))
                        ? wlsf_pkg::SAT_NEG : quo_round[wlsf_pkg::OUT_W-1:0];
            fixed_val = -fixed_mag;
        end
        else
        begin
            fixed_mag = (quo_round > wlsf_pkg::QUO_W'(wlsf_pkg::SAT_POS))
                        ? wlsf_pkg::SAT_POS : quo_round[wlsf_pkg::OUT_W-1:0];
            fixed_val = fixed_mag;
        end
    end

    assign solve_go = ((state_reg == S_IDLE) && start && !room && last)
                   || ((state_reg == S_ACC) && last_reg);
    assign singular_fire  = (state_reg == S_EVAL) && (det_sel_reg == wlsf_pkg::DET_MAIN)
                         && acc_zero;
    assign next_det       = (state_reg == S_EVAL) && (det_sel_reg == wlsf_pkg::DET_MAIN)
                         && !acc_zero;
    assign intercept_fire = (state_reg == S_DIV) && div_done
                         && (det_sel_reg == wlsf_pkg::DET_INTERCEPT);
    assign result_fire    = singular_fire
                         || ((state_reg == S_DIV) && div_done
                             && (det_sel_reg == wlsf_pkg::DET_SLOPE));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (room)
                        state_next = S_WX;
                    else if (last)
                        state_next = S_PROD;
                end
            end
            S_WX:  state_next = S_WY;
            S_WY:  state_next = S_WXX;
            S_WXX: state_next = S_WXY;
            S_WXY: state_next = S_ACC;
            S_ACC: state_next = last_reg ? S_PROD : S_IDLE;
            S_PROD:
            begin
                if (step_reg == STEP_LAST)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (det_sel_reg != wlsf_pkg::DET_MAIN)
                    state_next = S_DIV;
                else if (acc_zero)
                    state_next = S_IDLE;
                else
                    state_next = S_PROD;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = (det_sel_reg == wlsf_pkg::DET_INTERCEPT) ? S_PROD : S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            sum_w_reg    <= '0;
            sum_wx_reg   <= '0;
            sum_wy_reg   <= '0;
            sum_wxx_reg  <= '0;
            sum_wxy_reg  <= '0;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            det_sel_reg  <= wlsf_pkg::DET_MAIN;
            step_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= result_fire;

            if ((state_reg == S_IDLE) && start && !room)
                overflow_reg <= 1'b1;
            if (state_reg == S_WY)
                sum_wx_reg <= sum_wx_reg + (sx ? (-p_sx) : p_sx);
            if (state_reg == S_WXX)
                sum_wy_reg <= sum_wy_reg + (sy ? (-p_sx) : p_sx);
            if (state_reg == S_WXY)
                sum_wxx_reg <= sum_wxx_reg + p_sxx;
            if (state_reg == S_ACC)
            begin
                sum_wxy_reg <= sum_wxy_reg + ((sx ^ sy) ? (-p_sxx) : p_sxx);
                sum_w_reg   <= sum_w_reg + wlsf_pkg::SW_W'(w_reg);
                count_reg   <= count_reg + CNT_W'(1);
            end

            if (result_fire)
            begin
                sum_w_reg    <= '0;
                sum_wx_reg   <= '0;
                sum_wy_reg   <= '0;
                sum_wxx_reg  <= '0;
                sum_wxy_reg  <= '0;
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end

            if (solve_go)
                det_sel_reg <= wlsf_pkg::DET_MAIN;
            else if (next_det)
                det_sel_reg <= wlsf_pkg::DET_INTERCEPT;
            else if (intercept_fire)
                det_sel_reg <= wlsf_pkg::DET_SLOPE;

            if (solve_go || next_det || intercept_fire)
                step_reg <= '0;
            else if (state_reg == S_PROD)
                step_reg <= step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            x_reg    <= x_value;
            y_reg    <= y_value;
            w_reg    <= weight;
            last_reg <= last;
        end
        if (state_reg == S_WY)
            wx_mag_reg <= product[wlsf_pkg::MUL_W-1:0];

        if (state_reg == S_PROD)
        begin
            pp_neg_reg   <= issue_neg;
            pp_shift_reg <= issue_shift;
        end

        if (solve_go || next_det || intercept_fire)
            acc_reg <= '0;
        else if ((state_reg == S_PROD) && (step_reg != 4'd0))
            acc_reg <= acc_reg + pp_term;

        if ((state_reg == S_EVAL) && (det_sel_reg == wlsf_pkg::DET_MAIN))
        begin
            den_mag_reg <= acc_mag;
            den_neg_reg <= acc_neg;
        end
        if (div_start)
            quo_neg_reg <= acc_neg ^ den_neg_reg;

        if (singular_fire)
        begin
            intercept_reg <= '0;
            slope_reg     <= '0;
            status_reg    <= wlsf_pkg::STATUS_SINGULAR;
        end
        if (intercept_fire)
            intercept_reg <= fixed_val;
        if ((state_reg == S_DIV) && div_done && (det_sel_reg == wlsf_pkg::DET_SLOPE))
        begin
            slope_reg  <= fixed_val;
            status_reg <= overflow_reg ? wlsf_pkg::STATUS_IGNORED : wlsf_pkg::STATUS_OK;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign intercept = intercept_reg;
    assign slope     = slope_reg;
    assign status    = status_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == wlsf_pkg::STATUS_SINGULAR)) |-> ((intercept == '0) && (slope == '0)))
        else $error("singular result with nonzero fit");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && room) |=> busy)
        else $error("held sample did not start accumulation");

    a_div_in_solve: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide step");

endmodule

`default_nettype wire
